/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define IDD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds across reset.
`define IDD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/idd_pkg.sv */
// Shared constants and types for the incremental deadlock detector.
package idd_pkg;

  localparam int PROC_ID_W    = 5;
  localparam int RES_ID_W     = 5;
  localparam int DIR_W        = 2;
  localparam int IDX_W        = 32;
  localparam int MASK_W       = 32;
  localparam int IN_TDATA_W   = 16;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 64;
  localparam int OUT_TUSER_W  = 1;
  localparam int MAX_NODES    = 64;
  localparam int DEF_NUM_PROCS = 32;
  localparam int DEF_NUM_RES   = 32;

  localparam logic [DIR_W-1:0] DIR_REQUEST = 2'd0;
  localparam logic [DIR_W-1:0] DIR_ASSIGN  = 2'd1;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // transaction taken on the input channel
    logic step;    // run one elimination round
    logic load;    // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic halted;   // deadlock already reported, result frozen
    logic changed;  // next round would still remove nodes
  } stat_t;

endpackage

/* rtl/incremental_deadlock_detector_top.sv */
// Top level of the incremental deadlock detector.
//
//  Channel  Direction  Payload
//  in_*     slave      tdata: process_id, resource_id; tuser: direction
//  out_*    master     tdata: edge_index, process_mask; tuser: deadlock
//
// An item is accepted, runs elimination rounds (one per removed layer of nodes,
// plus the round that sees no change) and is then handed off. Once a deadlock
// is held, an item skips the rounds and goes straight to hand-off.
// Synchronous active-low reset clears the graph, counter and halt flag.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the block in its hand-off cycle.
module incremental_deadlock_detector_top #(
  parameter int NUM_PROCS = idd_pkg::DEF_NUM_PROCS,
  parameter int NUM_RES   = idd_pkg::DEF_NUM_RES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [idd_pkg::IN_TDATA_W-1:0]  in_tdata,   // [4:0] process_id, [9:5] resource_id
  input  logic [idd_pkg::IN_TUSER_W-1:0]  in_tuser,   // [1:0] direction
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [idd_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] edge_index, [63:32] process_mask
  output logic [idd_pkg::OUT_TUSER_W-1:0] out_tuser   // [0] deadlock
);

  idd_pkg::cmd_t  cmd;
  idd_pkg::stat_t stat;

  logic                          deadlock;
  logic [idd_pkg::IDX_W-1:0]     edge_index;
  logic [idd_pkg::MASK_W-1:0]    process_mask;

  idd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  idd_datapath #(
    .NUM_PROCS (NUM_PROCS),
    .NUM_RES   (NUM_RES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_process_id    (in_tdata[4:0]),
    .in_resource_id   (in_tdata[9:5]),
    .in_direction     (in_tuser[1:0]),
    .out_deadlock     (deadlock),
    .out_edge_index   (edge_index),
    .out_process_mask (process_mask)
  );

  assign out_tdata = {process_mask, edge_index};
  assign out_tuser = deadlock;

endmodule

/* rtl/idd_ctrl.sv */
// Controller: sequences accept, elimination rounds and result hand-off.
module idd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  idd_pkg::stat_t    stat,
  output idd_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ELIM = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = in_tvalid && (state_r == ST_IDLE);
    cmd.step   = (state_r == ST_ELIM);
    cmd.load   = (state_r == ST_DONE) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = stat.halted ? ST_DONE : ST_ELIM;
      end
      ST_ELIM: begin
        if (!stat.changed) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/idd_datapath.sv */
// Datapath: edge matrices, elimination masks, item counter and result registers.
module idd_datapath #(
  parameter int NUM_PROCS = idd_pkg::DEF_NUM_PROCS,
  parameter int NUM_RES   = idd_pkg::DEF_NUM_RES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  idd_pkg::cmd_t                 cmd,
  output idd_pkg::stat_t                stat,
  input  logic [idd_pkg::PROC_ID_W-1:0] in_process_id,
  input  logic [idd_pkg::RES_ID_W-1:0]  in_resource_id,
  input  logic [idd_pkg::DIR_W-1:0]     in_direction,
  output logic                          out_deadlock,
  output logic [idd_pkg::IDX_W-1:0]     out_edge_index,
  output logic [idd_pkg::MASK_W-1:0]    out_process_mask
);

  localparam int PIW  = $clog2(NUM_PROCS);
  localparam int RIW  = $clog2(NUM_RES);
  localparam int ExtW = idd_pkg::MAX_NODES;

  // req_r[p] bit r: request p->r; asg_r[r] bit p: assignment r->p
  logic [NUM_RES-1:0]   req_r [NUM_PROCS];
  logic [NUM_PROCS-1:0] asg_r [NUM_RES];

  logic [NUM_PROCS-1:0] gone_p_r, gone_p_nxt;
  logic [NUM_RES-1:0]   gone_r_r, gone_r_nxt;

  logic [idd_pkg::IDX_W-1:0]  cnt_r;
  logic [idd_pkg::IDX_W-1:0]  idx_r;
  logic                       halted_r;
  logic [idd_pkg::IDX_W-1:0]  held_idx_r;
  logic [idd_pkg::MASK_W-1:0] held_mask_r;
  logic                       dl_r;
  logic [idd_pkg::IDX_W-1:0]  oidx_r;
  logic [idd_pkg::MASK_W-1:0] omask_r;

  logic [PIW-1:0]       p_idx;
  logic [RIW-1:0]       r_idx;
  logic                 ids_ok;
  logic                 take;
  logic [NUM_PROCS-1:0] stuck;
  logic [ExtW-1:0]      stuck_ext;
  logic [idd_pkg::MASK_W-1:0] stuck_mask;
  logic                 deadlock_now;

  assign p_idx  = PIW'(in_process_id);
  assign r_idx  = RIW'(in_resource_id);
  assign ids_ok = (int'(in_process_id) < NUM_PROCS) && (int'(in_resource_id) < NUM_RES);
  assign take   = cmd.accept && !halted_r;

  // One elimination round, all nodes in parallel
  always_comb begin
    for (int i = 0; i < NUM_PROCS; i++) begin
      gone_p_nxt[i] = gone_p_r[i] | ~|(req_r[i] & ~gone_r_r);
    end
    for (int j = 0; j < NUM_RES; j++) begin
      gone_r_nxt[j] = gone_r_r[j] | ~|(asg_r[j] & ~gone_p_r);
    end
  end

  assign stat.changed = (gone_p_nxt != gone_p_r) || (gone_r_nxt != gone_r_r);
  assign stat.halted  = halted_r;

  assign stuck        = ~gone_p_r;
  assign stuck_ext    = ExtW'(stuck);
  assign stuck_mask   = stuck_ext[idd_pkg::MASK_W-1:0];
  assign deadlock_now = |stuck;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PROCS; i++) req_r[i] <= '0;
      for (int j = 0; j < NUM_RES; j++) asg_r[j] <= '0;
      cnt_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      if (take) begin
        if (ids_ok && in_direction == idd_pkg::DIR_REQUEST) req_r[p_idx][r_idx] <= 1'b1;
        if (ids_ok && in_direction == idd_pkg::DIR_ASSIGN)  asg_r[r_idx][p_idx] <= 1'b1;
        if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.load && !halted_r && deadlock_now) halted_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_r    <= cnt_r;
      gone_p_r <= '0;
      gone_r_r <= '0;
    end else if (cmd.step) begin
      gone_p_r <= gone_p_nxt;
      gone_r_r <= gone_r_nxt;
    end
    if (cmd.load) begin
      if (halted_r) begin
        dl_r    <= 1'b1;
        oidx_r  <= held_idx_r;
        omask_r <= held_mask_r;
      end else if (deadlock_now) begin
        dl_r        <= 1'b1;
        oidx_r      <= idx_r;
        omask_r     <= stuck_mask;
        held_idx_r  <= idx_r;
        held_mask_r <= stuck_mask;
      end else begin
        dl_r    <= 1'b0;
        oidx_r  <= idx_r;
        omask_r <= '0;
      end
    end
  end

  assign out_deadlock     = dl_r;
  assign out_edge_index   = oidx_r;
  assign out_process_mask = omask_r;

endmodule

/* rtl/idd_checker.sv */
// Port-level checks for the deadlock detector, bound to the top level.
`include "assert_macros.svh"

module idd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [idd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [idd_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // stalled result must hold
  `IDD_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "output changed while stalled")

  // one item at a time: no second transaction right after an accepted one
  `IDD_ASSERT(a_in_one, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "input taken while busy")

  // no deadlock means an empty process mask
  `IDD_ASSERT(a_mask_zero, clk, rst_n, (out_tvalid && !out_tuser[0]) |-> (out_tdata[63:32] == 32'd0), "mask set without deadlock")

  // reset empties the output register
  `IDD_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind incremental_deadlock_detector_top idd_checker u_idd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
